FILE: src/rbpe_pkg.sv
// Package for the run-length bitmap pixel expander.
// Holds the word types, register and color-depth codes, and the RGB332 widening function.
// Depends on nothing.
`default_nettype none

package rbpe_pkg;

  // Color depth codes as held in the color_depth register.
  localparam logic [1:0] DEPTH_MONO   = 2'd0;
  localparam logic [1:0] DEPTH_RGB332 = 2'd1;
  localparam logic [1:0] DEPTH_RGB565 = 2'd2;
  // The fourth code has no pixel format; words are dropped and the run state kept unless end of image.
  localparam logic [1:0] DEPTH_NONE   = 2'd3;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_COLOR_DEPTH = 3'd0;
  localparam logic [2:0] REG_RLE_ENABLE  = 3'd1;
  localparam logic [2:0] REG_FG_COLOR    = 3'd2;
  localparam logic [2:0] REG_BG_COLOR    = 3'd3;
  localparam logic [2:0] REG_AREA_WIDTH  = 3'd4;
  localparam logic [2:0] REG_AREA_HEIGHT = 3'd5;

  localparam logic [15:0] FG_RESET = 16'hFFFF;

  typedef struct packed {
    logic [15:0] data_word;
    logic        end_of_image;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [15:0] group_repeat;
    logic        group_last;
  } out_word_t;

  // Configuration seen by the datapath; limit is (width+1)*(height+1).
  typedef struct packed {
    logic [1:0]  color_depth;
    logic        rle_enable;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [32:0] limit;
  } cfg_t;

  // One pixel group as handed from the decoder to the serializer.
  typedef struct packed {
    logic        mono;
    logic [7:0]  bits;
    logic [15:0] pixel;
    logic [15:0] repeat_count;
  } group_t;

  function automatic logic [15:0] rgb332_to_565(input logic [7:0] b);
    rgb332_to_565 = {b[7:5], 2'b00, b[4:2], 3'b000, b[1:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

FILE: src/rbpe_cfg.sv
// Configuration registers of the pixel expander behind an APB-style port.
// Also keeps the pixel limit for RGB565 run-length mode. Depends on rbpe_pkg.
`default_nettype none

module rbpe_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output rbpe_pkg::cfg_t     cfg_o
);

  logic [1:0]  depth_q, depth_d;
  logic        rle_q, rle_d;
  logic [15:0] fg_q, fg_d;
  logic [15:0] bg_q, bg_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [32:0] limit_q, limit_d;
  logic [33:0] product;
  logic        wr_en;
  logic [2:0]  index;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    depth_d  = depth_q;
    rle_d    = rle_q;
    fg_d     = fg_q;
    bg_d     = bg_q;
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (index)
        rbpe_pkg::REG_COLOR_DEPTH: depth_d  = pwdata[1:0];
        rbpe_pkg::REG_RLE_ENABLE:  rle_d    = pwdata[0];
        rbpe_pkg::REG_FG_COLOR:    fg_d     = pwdata[15:0];
        rbpe_pkg::REG_BG_COLOR:    bg_d     = pwdata[15:0];
        rbpe_pkg::REG_AREA_WIDTH:  width_d  = pwdata[15:0];
        rbpe_pkg::REG_AREA_HEIGHT: height_d = pwdata[15:0];
        default: ;
      endcase
    end
    // The product never exceeds 2^32, so 33 bits hold it.
    product = ({1'b0, width_d} + 17'd1) * ({1'b0, height_d} + 17'd1);
    limit_d = product[32:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= rbpe_pkg::DEPTH_MONO;
      rle_q    <= 1'b0;
      fg_q     <= rbpe_pkg::FG_RESET;
      bg_q     <= '0;
      width_q  <= '0;
      height_q <= '0;
      limit_q  <= 33'd1;
    end else begin
      depth_q  <= depth_d;
      rle_q    <= rle_d;
      fg_q     <= fg_d;
      bg_q     <= bg_d;
      width_q  <= width_d;
      height_q <= height_d;
      limit_q  <= limit_d;
    end
  end

  always_comb begin
    unique case (index)
      rbpe_pkg::REG_COLOR_DEPTH: prdata = {30'd0, depth_q};
      rbpe_pkg::REG_RLE_ENABLE:  prdata = {31'd0, rle_q};
      rbpe_pkg::REG_FG_COLOR:    prdata = {16'd0, fg_q};
      rbpe_pkg::REG_BG_COLOR:    prdata = {16'd0, bg_q};
      rbpe_pkg::REG_AREA_WIDTH:  prdata = {16'd0, width_q};
      rbpe_pkg::REG_AREA_HEIGHT: prdata = {16'd0, height_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = '{color_depth: depth_q, rle_enable: rle_q, fg_color: fg_q,
                   bg_color: bg_q, limit: limit_q};

endmodule

`default_nettype wire

FILE: src/rbpe_decode.sv
// Run-header decoder of the pixel expander: run state and pixel group forming.
// Depends on rbpe_pkg.
`default_nettype none

module rbpe_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rbpe_pkg::cfg_t     cfg_i,
  input  wire logic               accept_i,
  input  wire rbpe_pkg::in_word_t word_i,
  output logic                    load_o,
  output rbpe_pkg::group_t        group_o
);

  logic        awaiting_q, awaiting_d;
  logic        literal_q, literal_d;
  logic [15:0] remain_q, remain_d;
  logic [32:0] emitted_q, emitted_d;
  logic        finished_q, finished_d;

  logic        gen;
  logic [15:0] rep;
  logic [15:0] cnt;
  logic [14:0] hdr_cnt;
  logic [33:0] sum;
  logic [15:0] w;

  assign w       = word_i.data_word;
  assign hdr_cnt = w[14:0];

  always_comb begin
    awaiting_d = awaiting_q;
    literal_d  = literal_q;
    remain_d   = remain_q;
    emitted_d  = emitted_q;
    finished_d = finished_q;
    gen        = 1'b0;
    rep        = 16'd1;
    cnt        = (remain_q == 16'd0) ? 16'd1 : remain_q;
    sum        = {1'b0, emitted_q} + {18'd0, cnt};

    if (cfg_i.color_depth == rbpe_pkg::DEPTH_NONE) begin
      gen = 1'b0;
    end else if (!cfg_i.rle_enable) begin
      gen = 1'b1;
    end else if (finished_q) begin
      gen = 1'b0;
    end else if (awaiting_q) begin
      if (cfg_i.color_depth == rbpe_pkg::DEPTH_RGB565) begin
        if (emitted_q >= cfg_i.limit) begin
          finished_d = 1'b1;
        end else begin
          literal_d  = w[15];
          remain_d   = (hdr_cnt == 15'd0) ? 16'd1 : {1'b0, hdr_cnt};
          awaiting_d = 1'b0;
        end
      end else begin
        literal_d  = w[7];
        remain_d   = {9'd0, w[6:0]} + 16'd1;
        awaiting_d = 1'b0;
      end
    end else begin
      gen = 1'b1;
      if (literal_q) begin
        rep      = 16'd1;
        remain_d = cnt - 16'd1;
        if (cnt == 16'd1) begin
          awaiting_d = 1'b1;
        end
      end else begin
        rep        = cnt;
        remain_d   = '0;
        awaiting_d = 1'b1;
      end
      sum = {1'b0, emitted_q} + {18'd0, rep};
      if (cfg_i.color_depth == rbpe_pkg::DEPTH_RGB565) begin
        emitted_d = sum[33] ? '1 : sum[32:0];
      end
    end

    if (word_i.end_of_image) begin
      awaiting_d = 1'b1;
      literal_d  = 1'b0;
      remain_d   = '0;
      emitted_d  = '0;
      finished_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      literal_q  <= 1'b0;
      remain_q   <= '0;
      emitted_q  <= '0;
      finished_q <= 1'b0;
    end else if (accept_i) begin
      awaiting_q <= awaiting_d;
      literal_q  <= literal_d;
      remain_q   <= remain_d;
      emitted_q  <= emitted_d;
      finished_q <= finished_d;
    end
  end

  assign load_o  = accept_i && gen;
  assign group_o = '{
    mono:         (cfg_i.color_depth == rbpe_pkg::DEPTH_MONO),
    bits:         w[7:0],
    pixel:        (cfg_i.color_depth == rbpe_pkg::DEPTH_RGB332) ?
                  rbpe_pkg::rgb332_to_565(w[7:0]) : w,
    repeat_count: rep
  };

endmodule

`default_nettype wire

FILE: src/rbpe_serial.sv
// Group register and pixel serializer of the pixel expander.
// Sends one pixel per output word. Depends on rbpe_pkg.
`default_nettype none

module rbpe_serial (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire rbpe_pkg::group_t  group_i,
  input  wire logic [15:0]       fg_i,
  input  wire logic [15:0]       bg_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rbpe_pkg::out_word_t    out_word_o
);

  logic             valid_q;
  logic [2:0]       idx_q;
  rbpe_pkg::group_t group_q;
  logic             take;
  logic             last;
  logic             bit_sel;

  assign last    = !group_q.mono || (idx_q == 3'd7);
  assign take    = valid_q && !out_stall_i;
  assign free_o  = !valid_q || (take && last);
  assign bit_sel = group_q.bits[3'd7 - idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take && last) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      group_q <= group_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = '{
    pixel:        group_q.mono ? (bit_sel ? fg_i : bg_i) : group_q.pixel,
    group_repeat: group_q.repeat_count,
    group_last:   last
  };

endmodule

`default_nettype wire

FILE: src/rle_bitmap_pixel_expander.sv
// Top level of the run-length bitmap pixel expander (RGB565 output).
// Instantiates rbpe_cfg, rbpe_decode and rbpe_serial; depends on rbpe_pkg.
//
// Use: image data words enter on the input channel (in_valid_i, in_stall_o,
// in_word_i); RGB565 pixels leave on the output channel (out_valid_o,
// out_stall_i, out_word_o), one pixel per output word. A word moves at a
// rising edge where valid is high and stall is low. Configuration is written
// through the APB-style port while the block is idle; pready is always high.
// Latency: a word that yields pixels shows its first pixel in the cycle after
// it is accepted. Throughput: a one-bit-mode byte keeps the group register
// until all eight of its pixels are taken; RGB332 and RGB565 words go at one
// per cycle while the output does not stall. Run headers and ignored words
// yield no pixel. The rate is set by the single group register that the
// serializer drains one pixel per cycle while the output does not stall.
// The next word is taken in the same cycle that the last pixel of the current
// group is taken, so a stall on the output holds the input back as well.
// Reset clears the run state (a header is expected), empties the group register
// and loads the register reset values.
`default_nettype none

module rle_bitmap_pixel_expander (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input channel.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rbpe_pkg::in_word_t  in_word_i,
  // Output channel.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rbpe_pkg::out_word_t      out_word_o,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  rbpe_pkg::cfg_t   cfg;
  rbpe_pkg::group_t group;
  logic             load;
  logic             free;
  logic             accept;

  // A word is taken only when the group register is empty or empties now.
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  rbpe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbpe_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .word_i   (in_word_i),
    .load_o   (load),
    .group_o  (group)
  );

  // Colors are read live; the user must ensure configuration only changes while no group waits; nothing enforces it.
  rbpe_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .group_i     (group),
    .fg_i        (cfg.fg_color),
    .bg_i        (cfg.bg_color),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

FILE: test/rle_bitmap_pixel_expander_test.sv
// Self-checking testbench for the run-length bitmap pixel expander.
// Drives image words and APB register writes, predicts every RGB565 pixel word
// and checks the output stream; depends on rbpe_pkg and rle_bitmap_pixel_expander.
`timescale 1ns / 100ps

module rle_bitmap_pixel_expander_test;

  // Run bounds. The cycle limit is many times the slowest legal run:
  // about 400 words of eight pixels each, stalls, sender gaps and holds.
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          END_CYCLES    = 20;
  localparam int          PHASE_WORDS   = 28;
  localparam int          NUM_PHASES    = 9;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [32:0] PIX_MAX       = 33'h1_FFFF_FFFF;

  // Receiver stall styles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_style_e;

  // DUT connections. Every input has a known value from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  rbpe_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rbpe_pkg::out_word_t out_word_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [4:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  rle_bitmap_pixel_expander u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixels that the decoder must still produce, oldest first.
  rbpe_pkg::out_word_t expected_pixels[$];
  rbpe_pkg::out_word_t pending_pixel;

  // Shadow copy of the configuration registers, at their reset values.
  logic [1:0]  cfg_depth  = rbpe_pkg::DEPTH_MONO;
  logic        cfg_rle    = 1'b0;
  logic [15:0] cfg_fg     = rbpe_pkg::FG_RESET;
  logic [15:0] cfg_bg     = 16'h0000;
  logic [15:0] cfg_width  = 16'h0000;
  logic [15:0] cfg_height = 16'h0000;

  // Shadow copy of the run decoder state.
  logic        st_header_due = 1'b1;
  logic        st_literal    = 1'b0;
  logic [15:0] st_remaining  = 16'h0000;
  logic [32:0] st_pixels     = '0;
  logic        st_finished   = 1'b0;

  // Stimulus control, shared between the test tasks and the idling processes.
  stall_style_e stall_style   = STALL_RANDOM;
  logic [15:0]  stall_pattern = 16'hB38D;
  int           hold_left     = 0;
  logic         sender_gaps   = 1'b1;
  int           burst_left    = 1;

  // Counters.
  int cycle_count    = 0;
  int words_sent     = 0;
  int words_decoded  = 0;
  int pixels_checked = 0;
  int mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  // Queue the pixel words that one data word expands to. A one-bit byte gives
  // eight pixels, MSB first; the other depths give a single pixel.
  function automatic void queue_group_pixels(input logic [15:0] data, input logic [15:0] rep);
    rbpe_pkg::out_word_t px;
    logic [7:0] b;
    b = data[7:0];
    px.group_repeat = rep;
    if (cfg_depth == rbpe_pkg::DEPTH_MONO) begin
      for (int k = 7; k >= 0; k--) begin
        px.pixel      = b[k] ? cfg_fg : cfg_bg;
        px.group_last = (k == 0);
        expected_pixels.push_back(px);
      end
    end else begin
      if (cfg_depth == rbpe_pkg::DEPTH_RGB332) begin
        // Red to 15..13, green to 10..8, blue to 4..3; the rest stays zero.
        px.pixel = ({8'h00, b & 8'hE0} << 8) | ({8'h00, b & 8'h1C} << 6) |
                   ({8'h00, b & 8'h03} << 3);
      end else begin
        px.pixel = data;
      end
      px.group_last = 1'b1;
      expected_pixels.push_back(px);
    end
  endfunction

  // Advance the run decoder by one accepted input word.
  function automatic void predict_word(input rbpe_pkg::in_word_t w);
    logic [15:0] cnt;
    logic [15:0] rep;
    logic [32:0] limit;
    logic [33:0] sum;
    if (cfg_depth == rbpe_pkg::DEPTH_NONE) begin
      // No pixel format: the word is dropped and the run state is kept.
      words_decoded++;
    end else if (!cfg_rle) begin
      // Raw stream: every word is pixel data.
      words_decoded++;
      queue_group_pixels(w.data_word, 16'd1);
    end else if (!st_finished) begin
      words_decoded++;
      if (st_header_due) begin
        limit = (33'(cfg_width) + 33'd1) * (33'(cfg_height) + 33'd1);
        if (cfg_depth == rbpe_pkg::DEPTH_RGB565 && st_pixels >= limit) begin
          // The image is complete: ignore everything up to end of image.
          st_finished = 1'b1;
        end else if (cfg_depth == rbpe_pkg::DEPTH_RGB565) begin
          st_literal    = w.data_word[15];
          st_remaining  = (w.data_word[14:0] == 15'd0) ? 16'd1 : {1'b0, w.data_word[14:0]};
          st_header_due = 1'b0;
        end else begin
          st_literal    = w.data_word[7];
          st_remaining  = {9'd0, w.data_word[6:0]} + 16'd1;
          st_header_due = 1'b0;
        end
      end else begin
        cnt = (st_remaining == 16'd0) ? 16'd1 : st_remaining;
        if (st_literal) begin
          rep          = 16'd1;
          cnt          = cnt - 16'd1;
          st_remaining = cnt;
          if (cnt == 16'd0) st_header_due = 1'b1;
        end else begin
          // A repeat run is one data word whose group carries the count.
          rep           = cnt;
          st_remaining  = 16'd0;
          st_header_due = 1'b1;
        end
        queue_group_pixels(w.data_word, rep);
        if (cfg_depth == rbpe_pkg::DEPTH_RGB565) begin
          sum       = 34'(st_pixels) + 34'(rep);
          st_pixels = (sum > 34'(PIX_MAX)) ? PIX_MAX : sum[32:0];
        end
      end
    end
    if (w.end_of_image) begin
      st_header_due = 1'b1;
      st_literal    = 1'b0;
      st_remaining  = 16'h0000;
      st_pixels     = '0;
      st_finished   = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0d] ERROR: %s", cycle_count, msg);
  endfunction

  // Every output word accepted at this edge is compared with the oldest
  // prediction. Values are sampled before the edge updates anything.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("pixel word with none predicted: pixel %h repeat %h last %b",
                               out_word_o.pixel, out_word_o.group_repeat,
                               out_word_o.group_last));
      end else begin
        pending_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (out_word_o.pixel !== pending_pixel.pixel ||
            out_word_o.group_repeat !== pending_pixel.group_repeat ||
            out_word_o.group_last !== pending_pixel.group_last) begin
          note_failure($sformatf(
            "pixel word mismatch: expected %h/%h/%b, got %h/%h/%b (pixel/repeat/last)",
            pending_pixel.pixel, pending_pixel.group_repeat, pending_pixel.group_last,
            out_word_o.pixel, out_word_o.group_repeat, out_word_o.group_last));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired with %0d pixel words outstanding.", expected_pixels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: a long hold takes priority, otherwise the current stall style.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      case (stall_style)
        STALL_NONE: begin
          out_stall_i <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall_i <= ($urandom_range(0, 99) < 40);
        end
        default: begin
          out_stall_i   <= stall_pattern[0];
          stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks.
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until the decoder takes it. Valid stays high so
  // that a following call continues the burst without a bubble.
  task automatic send_word(input rbpe_pkg::in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    predict_word(w);
  endtask

  // Send one word as part of a burst; between bursts the sender goes quiet.
  task automatic offer_word(input logic [15:0] data, input logic eoi);
    rbpe_pkg::in_word_t w;
    int gap;
    w.data_word    = data;
    w.end_of_image = eoi;
    send_word(w);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and wait until every predicted pixel has arrived. Headers
  // yield no pixel, so a further settling wait lets the last one retire.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready. Only called when idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rbpe_pkg::REG_COLOR_DEPTH: cfg_depth  = value[1:0];
      rbpe_pkg::REG_RLE_ENABLE:  cfg_rle    = value[0];
      rbpe_pkg::REG_FG_COLOR:    cfg_fg     = value[15:0];
      rbpe_pkg::REG_BG_COLOR:    cfg_bg     = value[15:0];
      rbpe_pkg::REG_AREA_WIDTH:  cfg_width  = value[15:0];
      rbpe_pkg::REG_AREA_HEIGHT: cfg_height = value[15:0];
      default: ;
    endcase
  endtask

  // One well-formed run: a header, then the data words it asks for.
  task automatic send_run();
    logic        lit;
    logic [14:0] cnt15;
    int          cnt;
    int          n_data;
    lit = 1'($urandom_range(0, 1));
    if (cfg_depth == rbpe_pkg::DEPTH_RGB565) begin
      // Literal runs stay short; repeat counts use all fifteen bits.
      cnt15  = lit ? 15'($urandom_range(0, 4)) : 15'($urandom);
      offer_word({lit, cnt15}, 1'b0);
      n_data = lit ? ((cnt15 == 15'd0) ? 1 : int'(cnt15)) : 1;
    end else begin
      cnt    = lit ? $urandom_range(1, 4) : $urandom_range(1, 128);
      offer_word({8'($urandom), lit, 7'(cnt - 1)}, 1'b0);
      n_data = lit ? cnt : 1;
    end
    repeat (n_data) offer_word(16'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Raw streams at all three pixel depths, including the reset colors, all-zero and
  // all-one data, and upper bits that the byte modes must ignore.
  task automatic test_raw_depths();
    offer_word(16'h0000, 1'b0);
    offer_word(16'hFF5A, 1'b0);
    settle();
    write_reg(rbpe_pkg::REG_FG_COLOR, 32'h0000_1234);
    write_reg(rbpe_pkg::REG_BG_COLOR, 32'hFFFF_FFFF);
    offer_word(16'h00A5, 1'b1);
    offer_word(16'hABFF, 1'b0);
    settle();
    write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(rbpe_pkg::DEPTH_RGB332));
    offer_word(16'h00E0, 1'b0);
    offer_word(16'hFF1C, 1'b0);
    offer_word(16'h0003, 1'b0);
    settle();
    write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(rbpe_pkg::DEPTH_RGB565));
    offer_word(16'h0000, 1'b0);
    offer_word(16'hFFFF, 1'b0);
    settle();
  endtask

  // Run-length streams: literal and repeat headers at their count extremes,
  // a depth change in the middle of a run, end of image inside a run, and
  // the RGB565 pixel limit with the zero count and the longest repeat.
  task automatic test_rle_runs();
    write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(rbpe_pkg::DEPTH_MONO));
    write_reg(rbpe_pkg::REG_RLE_ENABLE, 32'd1);
    write_reg(rbpe_pkg::REG_FG_COLOR, 32'h0000_F81F);
    write_reg(rbpe_pkg::REG_BG_COLOR, 32'h0000_07E0);
    offer_word(16'h0080, 1'b0);  // literal, one word
    offer_word(16'h00C3, 1'b0);
    offer_word(16'h007F, 1'b0);  // repeat 128
    offer_word(16'hFF5A, 1'b0);
    offer_word(16'h0083, 1'b0);  // literal, four words
    offer_word(16'h0001, 1'b0);
    settle();
    // The run carries on in the new depth.
    write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(rbpe_pkg::DEPTH_RGB332));
    offer_word(16'h00E0, 1'b0);
    offer_word(16'h001C, 1'b0);
    offer_word(16'h0003, 1'b0);
    offer_word(16'h0005, 1'b0);  // repeat 6
    offer_word(16'h00FF, 1'b0);
    offer_word(16'h0082, 1'b0);  // literal of three, cut short by end of image
    offer_word(16'h00AA, 1'b0);
    offer_word(16'h0055, 1'b1);
    settle();
    // Two-pixel image in RGB565.
    write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(rbpe_pkg::DEPTH_RGB565));
    write_reg(rbpe_pkg::REG_AREA_WIDTH, 32'd0);
    write_reg(rbpe_pkg::REG_AREA_HEIGHT, 32'd1);
    offer_word(16'h0000, 1'b0);  // zero count acts as one
    offer_word(16'h1234, 1'b0);
    offer_word(16'h8002, 1'b0);  // literal of two runs past the limit
    offer_word(16'hFFFF, 1'b0);
    offer_word(16'h0000, 1'b0);
    offer_word(16'h8001, 1'b0);  // header at the limit ends the image
    offer_word(16'hABCD, 1'b0);
    offer_word(16'h7FFF, 1'b1);
    offer_word(16'h7FFF, 1'b0);  // longest repeat
    offer_word(16'h5555, 1'b0);
    offer_word(16'h8003, 1'b1);
    settle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // words, so the group register fills and the input stalls.
  task automatic test_backpressure();
    write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(rbpe_pkg::DEPTH_MONO));
    write_reg(rbpe_pkg::REG_RLE_ENABLE, 32'd0);
    sender_gaps = 1'b0;
    hold_left   = 300;
    repeat (16) offer_word(16'($urandom), 1'b0);
    settle();
    sender_gaps = 1'b1;
  endtask

  // Random phases over several register settings. Most traffic is well-formed
  // runs with random content; noise words and stray end-of-image words break
  // the runs, and the sender now and then waits for the output to drain.
  task automatic test_random_streams();
    int start;
    int pick;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      stall_style   = stall_style_e'(phase % 3);
      // Keep at least one open slot in the pattern so the receiver never locks up.
      stall_pattern = (16'($urandom) | 16'h0001) & 16'h7FFF;
      sender_gaps   = (phase % 2 == 0);
      write_reg(rbpe_pkg::REG_COLOR_DEPTH, 32'(phase % 3));
      write_reg(rbpe_pkg::REG_RLE_ENABLE, 32'(phase % 4 != 3));
      write_reg(rbpe_pkg::REG_FG_COLOR, (phase == 0) ? 32'h0 : 32'($urandom));
      write_reg(rbpe_pkg::REG_BG_COLOR, (phase == 0) ? 32'hFFFF : 32'($urandom));
      case (phase)
        2: begin
          write_reg(rbpe_pkg::REG_AREA_WIDTH, 32'($urandom_range(0, 7)));
          write_reg(rbpe_pkg::REG_AREA_HEIGHT, 32'($urandom_range(0, 7)));
        end
        5: begin
          write_reg(rbpe_pkg::REG_AREA_WIDTH, 32'hFFFF);
          write_reg(rbpe_pkg::REG_AREA_HEIGHT, 32'hFFFF);
        end
        8: begin
          write_reg(rbpe_pkg::REG_AREA_WIDTH, 32'd0);
          write_reg(rbpe_pkg::REG_AREA_HEIGHT, 32'($urandom_range(0, 3)));
        end
        default: begin
          write_reg(rbpe_pkg::REG_AREA_WIDTH, 32'($urandom_range(0, 15)));
          write_reg(rbpe_pkg::REG_AREA_HEIGHT, 32'($urandom_range(0, 15)));
        end
      endcase
      start = words_decoded;
      while (words_decoded - start < PHASE_WORDS) begin
        pick = $urandom_range(0, 15);
        if (!cfg_rle || pick == 0) begin
          offer_word(16'($urandom), ($urandom_range(0, 7) == 0));
        end else if (pick == 1 || (st_finished && pick < 8)) begin
          // End the image; after the pixel limit this is the only way on.
          offer_word(16'($urandom), 1'b1);
        end else if (pick == 2) begin
          settle();
        end else begin
          send_run();
        end
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_raw_depths();
    test_rle_runs();
    test_backpressure();
    test_random_streams();

    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      note_failure($sformatf("%0d predicted pixel words never arrived", expected_pixels.size()));

    $display("Sent %0d words (%0d decoded) and checked %0d pixel words,", words_sent,
             words_decoded, pixels_checked);
    $display("over all three depths, raw and run-length coded; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rbpe_pkg.sv
src/rbpe_cfg.sv
src/rbpe_decode.sv
src/rbpe_serial.sv
src/rle_bitmap_pixel_expander.sv
test/rle_bitmap_pixel_expander_test.sv
